// ===== rtl/ist_pkg.sv =====
// Shared types and codes for the interval set table.
package ist_pkg;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_WRITE  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   // Per-cell control: shift takes the right neighbor, load takes the new entry.
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

// ===== rtl/ist_cell.sv =====
// One storage cell of the interval chain.
module ist_cell
   import ist_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  cell_ctl_type     ctl,
   input  logic [WIDTH-1:0] nbr_data,
   input  logic [WIDTH-1:0] new_data,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = new_data;
      end else if (ctl.shift) begin
         data_in = nbr_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule

// ===== rtl/interval_set_table.sv =====
// Top level of the interval set table: cell chain, scan/rewrite sequencer, response register.
//
// Stores up to MAX_INTERVALS sorted, disjoint half-open intervals [start,end) in a chain of
// cells that works as a queue: the head cell feeds one datapath, results go back in at the
// tail. A request with an empty range or an unknown op goes straight to the finish state.
// Every other request first makes a scan pass that rotates all N stored entries once, then
// takes an exit step, to find the merge range, a split or a covering entry, and to
// decide whether the table would overflow. Add and remove then make a rewrite pass that
// pops each entry and pushes what survives. The finish state then loads the response
// register and the sequencer returns to idle. The chain is walked one entry per cycle
// through the head cell, except where the rewrite pass pushes without popping.
// A dropped add or remove (table full) leaves the table intact and answers
// status 1. A new request is taken as soon as the sequencer is idle, even while the previous
// response is still stalled.
module interval_set_table
   import ist_pkg::*;
#(
   parameter int MAX_INTERVALS = 64,
   parameter int COORD_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_left_edge,
   input  logic [31:0] req_right_edge,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_covered,
   output logic        rsp_status
);

   localparam int CW     = (COORD_BITS > 32) ? 32 : COORD_BITS;
   localparam int SPAN_W = 2 * CW;
   localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_INTERVALS);

   // sequencer state
   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [CNT_W-1:0] count_ff, count_in;   // committed entries
   logic [CNT_W-1:0] occ_ff, occ_in;       // entries in the chain right now
   logic [CNT_W-1:0] rem_ff, rem_in;       // entries still to pop this pass
   logic [CW-1:0]    lo_ff, lo_in;         // request range, widened by add merges
   logic [CW-1:0]    hi_ff, hi_in;
   logic             hit_ff, hit_in;       // add: something merged
   logic             split_ff, split_in;   // remove: one entry splits in two
   logic             cover_ff, cover_in;   // query: found a covering entry
   logic             ins_ff, ins_in;       // add: merged entry already pushed
   logic             pend_ff, pend_in;     // remove: upper piece still owed
   logic             res_cov_ff, res_cov_in;
   logic             res_st_ff, res_st_in;

   // response register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_covered_ff, rsp_covered_in;
   logic rsp_status_ff, rsp_status_in;

   // chain
   logic [SPAN_W-1:0] cell_q [MAX_INTERVALS];
   logic [SPAN_W-1:0] push_data;
   logic              pop, push;
   logic [CNT_W-1:0]  load_idx;

   logic [CW-1:0] h_start, h_end;
   logic [CW-1:0] in_lo, in_hi;
   logic          ovl, req_take;

   assign h_start = cell_q[0][SPAN_W-1:CW];
   assign h_end   = cell_q[0][CW-1:0];
   assign in_lo   = req_left_edge[CW-1:0];
   assign in_hi   = req_right_edge[CW-1:0];
   assign ovl     = (h_start <= hi_ff) && (lo_ff <= h_end);

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      count_in   = count_ff;
      occ_in     = occ_ff;
      rem_in     = rem_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      hit_in     = hit_ff;
      split_in   = split_ff;
      cover_in   = cover_ff;
      ins_in     = ins_ff;
      pend_in    = pend_ff;
      res_cov_in = res_cov_ff;
      res_st_in  = res_st_ff;
      pop        = 1'b0;
      push       = 1'b0;
      push_data  = cell_q[0];

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_covered_in = rsp_covered_ff;
      rsp_status_in  = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in      = op_type'(req_op);
               lo_in      = in_lo;
               hi_in      = in_hi;
               hit_in     = 1'b0;
               split_in   = 1'b0;
               cover_in   = 1'b0;
               ins_in     = 1'b0;
               pend_in    = 1'b0;
               rem_in     = count_ff;
               occ_in     = count_ff;
               res_cov_in = 1'b0;
               res_st_in  = 1'b0;
               // empty range or unknown op: answer right away
               if (in_lo >= in_hi || op_type'(req_op) == OP_NONE) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (rem_ff != '0) begin
               // rotate: head goes back in at the tail unchanged
               pop    = 1'b1;
               push   = 1'b1;
               rem_in = rem_ff - 1'b1;
               case (op_ff)
                  OP_ADD: begin
                     if (ovl) begin
                        hit_in = 1'b1;
                        if (h_start < lo_ff) lo_in = h_start;
                        if (h_end > hi_ff)   hi_in = h_end;
                     end
                  end
                  OP_REMOVE: begin
                     if (ovl && h_start < lo_ff && hi_ff < h_end) split_in = 1'b1;
                  end
                  OP_QUERY: begin
                     if (h_start <= lo_ff && h_end >= hi_ff) cover_in = 1'b1;
                  end
                  default: ;
               endcase
            end else begin
               rem_in = count_ff;
               case (op_ff)
                  OP_QUERY: begin
                     res_cov_in = cover_ff;
                     state_in   = S_FINISH;
                  end
                  OP_ADD: begin
                     if (!hit_ff && count_ff == MAX_CNT) begin
                        res_st_in = 1'b1;
                        state_in  = S_FINISH;
                     end else begin
                        state_in = S_WRITE;
                     end
                  end
                  OP_REMOVE: begin
                     if (split_ff && count_ff == MAX_CNT) begin
                        res_st_in = 1'b1;
                        state_in  = S_FINISH;
                     end else begin
                        state_in = S_WRITE;
                     end
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end

         S_WRITE: begin
            if (rem_ff != '0) begin
               if (op_ff == OP_ADD) begin
                  if (ovl) begin
                     pop = 1'b1;              // absorbed into the merged entry
                  end else if (!ins_ff && h_start > hi_ff) begin
                     push      = 1'b1;        // merged entry goes in ahead of head
                     push_data = {lo_ff, hi_ff};
                     ins_in    = 1'b1;
                  end else begin
                     pop  = 1'b1;
                     push = 1'b1;
                  end
               end else begin
                  if (!ovl) begin
                     pop  = 1'b1;
                     push = 1'b1;
                  end else if (h_start < lo_ff && hi_ff < h_end && !pend_ff) begin
                     push      = 1'b1;        // lower piece, keep head for upper
                     push_data = {h_start, lo_ff};
                     pend_in   = 1'b1;
                  end else if (h_start < lo_ff && hi_ff < h_end) begin
                     pop       = 1'b1;
                     push      = 1'b1;
                     push_data = {hi_ff, h_end};
                     pend_in   = 1'b0;
                  end else if (h_start < lo_ff) begin
                     pop       = 1'b1;
                     push      = 1'b1;
                     push_data = {h_start, lo_ff};
                  end else if (hi_ff < h_end) begin
                     pop       = 1'b1;
                     push      = 1'b1;
                     push_data = {hi_ff, h_end};
                  end else begin
                     pop = 1'b1;
                  end
               end
               if (pop) rem_in = rem_ff - 1'b1;
            end else if (op_ff == OP_ADD && !ins_ff) begin
               push      = 1'b1;              // merged entry lands at the end
               push_data = {lo_ff, hi_ff};
               ins_in    = 1'b1;
            end else begin
               state_in = S_FINISH;
            end
            case ({pop, push})
               2'b10:   occ_in = occ_ff - 1'b1;
               2'b01:   occ_in = occ_ff + 1'b1;
               default: occ_in = occ_ff;
            endcase
         end

         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               count_in       = occ_ff;
               rsp_valid_in   = 1'b1;
               rsp_covered_in = res_cov_ff;
               rsp_status_in  = res_st_ff;
               state_in       = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign load_idx = pop ? (occ_ff - 1'b1) : occ_ff;

   for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_chain
      cell_ctl_type      ctl;
      logic [SPAN_W-1:0] nbr;
      assign ctl.shift = pop;
      assign ctl.load  = push && (load_idx == CNT_W'(i));
      if (i == MAX_INTERVALS - 1) begin : g_last
         assign nbr = cell_q[i];
      end else begin : g_mid
         assign nbr = cell_q[i+1];
      end
      ist_cell #(
         .WIDTH(SPAN_W)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .nbr_data (nbr),
         .new_data (push_data),
         .q        (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         occ_ff       <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         occ_ff       <= occ_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      hit_ff         <= hit_in;
      split_ff       <= split_in;
      cover_ff       <= cover_in;
      ins_ff         <= ins_in;
      pend_ff        <= pend_in;
      res_cov_ff     <= res_cov_in;
      res_st_ff      <= res_st_in;
      rsp_covered_ff <= rsp_covered_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_covered = rsp_covered_ff;
   assign rsp_status  = rsp_status_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT && occ_ff <= MAX_CNT)
      else $error("interval count beyond table size");

   a_scan_keeps_occ: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> occ_ff == count_ff)
      else $error("scan pass changed chain occupancy");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside finish");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> occ_ff < MAX_CNT)
      else $error("push into a full chain");
`endif

endmodule

// ===== tb/interval_set_table_tb.sv =====
// Self-checking testbench for the interval set table: random add/remove/query traffic vs a model.
module interval_set_table_tb;
   import ist_pkg::*;

   localparam int MAX_IV = 64;
   localparam int LIMIT_CYCLES = 1500000;

   // Behavioral model of the table plus the queue of predicted responses.
   class ist_scoreboard;
      longint unsigned iv_lo[$];
      longint unsigned iv_hi[$];
      bit exp_covered[$];
      bit exp_status[$];
      int mismatches;

      // Predict the response for one accepted request and update the table copy.
      function void note_request(op_type op, logic [31:0] le, logic [31:0] re);
         longint unsigned lo, hi;
         longint unsigned nlo[$], nhi[$];
         bit cov, st;
         int pos;
         lo = le;
         hi = re;
         cov = 0;
         st = 0;
         if (lo < hi) begin
            case (op)
               OP_ADD: begin
                  foreach (iv_lo[i]) begin
                     if (iv_lo[i] <= hi && lo <= iv_hi[i]) begin
                        if (iv_lo[i] < lo) lo = iv_lo[i];
                        if (iv_hi[i] > hi) hi = iv_hi[i];
                     end else begin
                        nlo.insert(nlo.size(), iv_lo[i]);
                        nhi.insert(nhi.size(), iv_hi[i]);
                     end
                  end
                  if (nlo.size() + 1 > MAX_IV) st = 1;
                  else begin
                     pos = nlo.size();
                     for (int i = 0; i < nlo.size(); i++)
                        if (nlo[i] > hi) begin
                           pos = i;
                           break;
                        end
                     nlo.insert(pos, lo);
                     nhi.insert(pos, hi);
                     iv_lo = nlo;
                     iv_hi = nhi;
                  end
               end
               OP_REMOVE: begin
                  foreach (iv_lo[i]) begin
                     if (iv_lo[i] <= hi && lo <= iv_hi[i]) begin
                        if (iv_lo[i] < lo) begin
                           nlo.insert(nlo.size(), iv_lo[i]);
                           nhi.insert(nhi.size(), lo);
                        end
                        if (hi < iv_hi[i]) begin
                           nlo.insert(nlo.size(), hi);
                           nhi.insert(nhi.size(), iv_hi[i]);
                        end
                     end else begin
                        nlo.insert(nlo.size(), iv_lo[i]);
                        nhi.insert(nhi.size(), iv_hi[i]);
                     end
                  end
                  if (nlo.size() > MAX_IV) st = 1;
                  else begin
                     iv_lo = nlo;
                     iv_hi = nhi;
                  end
               end
               OP_QUERY: begin
                  foreach (iv_lo[i])
                     if (iv_lo[i] <= lo && iv_hi[i] >= hi) cov = 1;
               end
               default: ;
            endcase
         end
         exp_covered.insert(exp_covered.size(), cov);
         exp_status.insert(exp_status.size(), st);
      endfunction

      function void check_response(bit cov, bit st);
         bit ec, es;
         if (exp_covered.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response covered=%0d status=%0d", cov, st);
            return;
         end
         ec = exp_covered.pop_front();
         es = exp_status.pop_front();
         if (ec !== cov || es !== st) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: covered exp %0d got %0d, status exp %0d got %0d",
                        ec, cov, es, st);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_op = OP_QUERY;
   logic [31:0] req_left_edge = 0;
   logic [31:0] req_right_edge = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_covered;
   logic        rsp_status;

   ist_scoreboard sb;
   int  cycle_count = 0;
   bit  hold_off = 0;     // long receiver hold-off requested by the stimulus
   bit  stim_done = 0;

   interval_set_table #(.MAX_INTERVALS(MAX_IV), .COORD_BITS(32)) u_dut (.*);

   always #10 clock = ~clock;

   // Watchdog: fails the run past LIMIT_CYCLES, ample headroom for a slow full-table run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Response side: check each accepted response at the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_covered, rsp_status);
   end

   // Receiver stall pattern: runs of stall/no-stall, some stretches with no stalls,
   // plus one long hold-off so the block fills and pushes back on requests.
   initial begin : stall_gen
      int run;
      int mode;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            hold_off = 0;
            rsp_stall <= 0;
            @(posedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            run = $urandom_range(1, 30);
            rsp_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 2) == 0);
            repeat (run) @(posedge clock);
         end
      end
   end

   // Coordinates: mostly from a small window so ranges overlap, touch and split;
   // occasionally anywhere in the full 32-bit space.
   function automatic logic [31:0] pick_coord();
      if ($urandom_range(0, 9) == 0) return $urandom();
      return 32'h8000_0000 + $urandom_range(0, 600);
   endfunction

   // Present one request and hold it until accepted.
   task automatic send_request(op_type op, logic [31:0] le, logic [31:0] re);
      req_valid <= 1;
      req_op <= op;
      req_left_edge <= le;
      req_right_edge <= re;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, le, re);
   endtask

   task automatic idle_cycles(int n);
      req_valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   // Random request: mostly adds and queries of short ranges; some empty or unknown.
   task automatic send_random();
      op_type op;
      logic [31:0] le, re;
      int r;
      r = $urandom_range(0, 99);
      op = (r < 40) ? OP_ADD : (r < 65) ? OP_REMOVE : (r < 97) ? OP_QUERY : OP_NONE;
      le = pick_coord();
      if ($urandom_range(0, 19) == 0) re = pick_coord();   // may be empty
      else re = le + $urandom_range(1, 12);
      send_request(op, le, re);
   endtask

   initial begin : stimulus
      int burst;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, empty ranges, merge by touching, split, unknown op.
      send_request(OP_QUERY, 32'd0, 32'd1);
      send_request(OP_ADD, 32'd0, 32'hFFFF_FFFF);
      send_request(OP_QUERY, 32'd0, 32'hFFFF_FFFF);
      send_request(OP_REMOVE, 32'd100, 32'd200);       // split into two
      send_request(OP_QUERY, 32'd50, 32'd150);
      send_request(OP_QUERY, 32'd200, 32'd300);
      send_request(OP_ADD, 32'd100, 32'd100);          // empty range
      send_request(OP_REMOVE, 32'd500, 32'd10);        // inverted range
      send_request(OP_QUERY, 32'd7, 32'd7);
      send_request(OP_ADD, 32'd100, 32'd150);          // touches left piece
      send_request(OP_ADD, 32'd150, 32'd200);          // closes the gap
      send_request(OP_QUERY, 32'd0, 32'hFFFF_FFFF);
      send_request(OP_NONE, 32'd0, 32'hFFFF_FFFF);
      send_request(OP_NONE, 32'hFFFF_FFFF, 32'd0);
      send_request(OP_REMOVE, 32'd0, 32'hFFFF_FFFF);
      send_request(OP_QUERY, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
      // Fill the table past capacity with disjoint ranges: later adds report full.
      for (int i = 0; i < 66; i++)
         send_request(OP_ADD, 32'h5555_0000 + 4 * i, 32'h5555_0003 + 4 * i);
      // Remove that would split with a full table: dropped.
      send_request(OP_REMOVE, 32'h5555_0001, 32'h5555_0002);
      // Pressure: long receiver hold-off while requests keep coming.
      hold_off = 1;
      for (int i = 0; i < 8; i++) send_request(OP_QUERY, 32'h5555_0000 + i, 32'h5555_0001 + i);
      send_request(OP_REMOVE, 32'd0, 32'hFFFF_FFFF);

      // Random bursts with random gaps.
      for (int n = 0; n < 1400; ) begin
         burst = $urandom_range(1, 20);
         for (int k = 0; k < burst; k++) begin
            send_random();
            n++;
         end
         if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 40));
         if ($urandom_range(0, 60) == 0) send_request(OP_REMOVE, 32'd0, 32'hFFFF_FFFF);
      end
      req_valid <= 0;

      while (sb.exp_covered.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (sb.mismatches == 0 && sb.exp_covered.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/ist_pkg.sv
rtl/ist_cell.sv
rtl/interval_set_table.sv
tb/interval_set_table_tb.sv
